FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define AVR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("axis rotation port check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define AVR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("axis rotation port check failed");

`endif

FILE: src/avr_pkg.sv
`timescale 1ns / 1ps

package avr_pkg;

    // Axis selector codes
    localparam logic [1:0] MODE_HEADING = 2'd0;
    localparam logic [1:0] MODE_PITCH   = 2'd1;
    localparam logic [1:0] MODE_BANK    = 2'd2;

    // Quadrant codes of the exact pre-rotation
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Datapath format: guard bits below the Q16.16 point, room for CORDIC growth
    localparam int GUARD_BITS = 24;
    localparam int GAIN_SHIFT = 30 - GUARD_BITS;
    localparam int PROD_W     = 63;
    localparam int DATA_W     = 58;
    localparam int FIN_W      = DATA_W - GUARD_BITS;
    localparam int ATAN_COUNT = 30;

    // Reciprocal of the CORDIC gain in Q2.30
    localparam logic signed [31:0] KGAIN = 32'sd652032874;

    localparam logic [DATA_W-1:0] ROUND_HALF = DATA_W'(1) << (GUARD_BITS - 1);
    localparam logic [31:0]       QUAD_BIAS  = 32'h2000_0000;

    // Fields that ride along with the rotated pair
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } side_t;

    // atan(2^-i) in units of 2^-32 turn, truncated
    function automatic logic [31:0] atan_val(input int i);
        logic [31:0] a;
        case (i)
            0:       a = 32'h20000000;
            1:       a = 32'h12E4051D;
            2:       a = 32'h09FB385B;
            3:       a = 32'h051111D4;
            4:       a = 32'h028B0D43;
            5:       a = 32'h0145D7E1;
            6:       a = 32'h00A2F61E;
            7:       a = 32'h00517C55;
            8:       a = 32'h0028BE53;
            9:       a = 32'h00145F2E;
            10:      a = 32'h000A2F98;
            11:      a = 32'h000517CC;
            12:      a = 32'h00028BE6;
            13:      a = 32'h000145F3;
            14:      a = 32'h0000A2F9;
            15:      a = 32'h0000517C;
            16:      a = 32'h000028BE;
            17:      a = 32'h0000145F;
            18:      a = 32'h00000A2F;
            19:      a = 32'h00000517;
            20:      a = 32'h0000028B;
            21:      a = 32'h00000145;
            22:      a = 32'h000000A2;
            23:      a = 32'h00000051;
            24:      a = 32'h00000028;
            25:      a = 32'h00000014;
            26:      a = 32'h0000000A;
            27:      a = 32'h00000005;
            28:      a = 32'h00000002;
            29:      a = 32'h00000001;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

FILE: src/axis_vector_rotation.sv
`timescale 1ns / 1ps

// Channel   Dir   Handshake             Payload
// input     in    in_valid / in_ready   mode, vec_x, vec_y, vec_z, angle
// output    out   out_valid / out_ready rot_x, rot_y, rot_z
//
// The stages in order are gain multiply, quadrant pre-rotation,
// one register per CORDIC iteration, then round and saturate into the output register.
// One item per cycle is taken while no stall reaches the input.
// Reset clears only the stage valid bits; there is no clearing pass.
// A stage holds while the one after it is full and held; empty stages fill,
// so in_ready drops only when every stage and the output register are full.
module axis_vector_rotation #(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    input  logic [15:0]        angle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] rot_x,
    output logic signed [31:0] rot_y,
    output logic signed [31:0] rot_z
);

    localparam int N  = CORDIC_STAGES;
    localparam int DW = avr_pkg::DATA_W;
    localparam int PW = avr_pkg::PROD_W;
    localparam int FW = avr_pkg::FIN_W;

    // Multiply stage
    logic                 m_vld_reg;
    logic signed [PW-1:0] m_pu_reg, m_pu_next;
    logic signed [PW-1:0] m_pv_reg, m_pv_next;
    logic [1:0]           m_q_reg, m_q_next;
    logic signed [31:0]   m_r_reg, m_r_next;
    avr_pkg::side_t       m_side_reg, m_side_next;

    // CORDIC stages: index 0 is the pre-rotated pair, index k after k iterations
    logic                 c_vld_reg  [0:N];
    logic signed [DW-1:0] c_u_reg    [0:N];
    logic signed [DW-1:0] c_u_next   [0:N];
    logic signed [DW-1:0] c_v_reg    [0:N];
    logic signed [DW-1:0] c_v_next   [0:N];
    logic signed [31:0]   c_r_reg    [0:N-1];
    logic signed [31:0]   c_r_next   [0:N-1];
    avr_pkg::side_t       c_side_reg [0:N];
    logic                 c_en       [0:N];

    // Output register
    logic               out_vld_reg;
    logic signed [31:0] rot_x_reg, rot_x_next;
    logic signed [31:0] rot_y_reg, rot_y_next;
    logic signed [31:0] rot_z_reg, rot_z_next;

    logic               m_en;
    logic               out_adv;

    // Input angle path
    logic [ANGLE_BITS+15:0] ang_ext;
    logic [ANGLE_BITS-1:0]  th;
    logic [ANGLE_BITS-1:0]  phi;
    logic [31:0]            phi32;
    logic [31:0]            phi_bias;
    logic signed [31:0]     u_in;
    logic signed [31:0]     v_in;

    // Round, drop guard bits and clamp to 32 bits
    function automatic logic signed [31:0] finish(input logic signed [DW-1:0] a);
        logic signed [DW-1:0] t;
        logic signed [FW-1:0] s;
        t = a + $signed(avr_pkg::ROUND_HALF);
        s = FW'(t >>> avr_pkg::GUARD_BITS);
        if (s[FW-1:31] == {(FW - 31){1'b0}} || s[FW-1:31] == {(FW - 31){1'b1}}) begin
            finish = s[31:0];
        end else if (s[FW-1]) begin
            finish = 32'sh8000_0000;
        end else begin
            finish = 32'sh7FFF_FFFF;
        end
    endfunction

    // Stall chain: a stage moves when it is empty or its successor moves
    assign out_adv = !out_vld_reg || out_ready;
    assign c_en[N] = !c_vld_reg[N] || out_adv;
    generate
        for (genvar k = 0; k < N; k++) begin : g_en
            assign c_en[k] = !c_vld_reg[k] || c_en[k+1];
        end
    endgenerate
    assign m_en     = !m_vld_reg || c_en[0];
    assign in_ready = m_en;

    // Select the rotated pair, form quadrant and residual, apply the gain
    always_comb
    begin
        ang_ext  = {{ANGLE_BITS{1'b0}}, angle};
        th       = ang_ext[ANGLE_BITS-1:0];
        phi      = (mode == avr_pkg::MODE_BANK) ? th : (ANGLE_BITS'(0) - th);
        phi32    = {phi, {(32 - ANGLE_BITS){1'b0}}};
        phi_bias = phi32 + avr_pkg::QUAD_BIAS;
        m_q_next = phi_bias[31:30];
        m_r_next = $signed(phi32 - {m_q_next, 30'b0});
        case (mode)
            avr_pkg::MODE_HEADING:
            begin
                u_in = vec_x;
                v_in = vec_y;
            end
            avr_pkg::MODE_PITCH:
            begin
                u_in = vec_y;
                v_in = vec_z;
            end
            default:
            begin
                u_in = vec_x;
                v_in = vec_z;
            end
        endcase
        m_pu_next        = u_in * avr_pkg::KGAIN;
        m_pv_next        = v_in * avr_pkg::KGAIN;
        m_side_next.mode = mode;
        m_side_next.x    = vec_x;
        m_side_next.y    = vec_y;
        m_side_next.z    = vec_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_vld_reg <= 1'b0;
        end else if (m_en) begin
            m_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_en) begin
            m_pu_reg   <= m_pu_next;
            m_pv_reg   <= m_pv_next;
            m_q_reg    <= m_q_next;
            m_r_reg    <= m_r_next;
            m_side_reg <= m_side_next;
        end
    end

    // Drop the gain fraction and rotate by whole quarter turns
    logic signed [DW-1:0] pu;
    logic signed [DW-1:0] pv;

    always_comb
    begin
        pu = DW'(m_pu_reg >>> avr_pkg::GAIN_SHIFT);
        pv = DW'(m_pv_reg >>> avr_pkg::GAIN_SHIFT);
        case (m_q_reg)
            avr_pkg::QUAD_1:
            begin
                c_u_next[0] = -pv;
                c_v_next[0] = pu;
            end
            avr_pkg::QUAD_2:
            begin
                c_u_next[0] = -pu;
                c_v_next[0] = -pv;
            end
            avr_pkg::QUAD_3:
            begin
                c_u_next[0] = pv;
                c_v_next[0] = -pu;
            end
            default:
            begin
                c_u_next[0] = pu;
                c_v_next[0] = pv;
            end
        endcase
        c_r_next[0] = m_r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            c_vld_reg[0] <= 1'b0;
        end else if (c_en[0]) begin
            c_vld_reg[0] <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_en[0]) begin
            c_u_reg[0]    <= c_u_next[0];
            c_v_reg[0]    <= c_v_next[0];
            c_r_reg[0]    <= c_r_next[0];
            c_side_reg[0] <= m_side_reg;
        end
    end

    // One CORDIC iteration per stage, steered by the sign of the residual
    generate
        for (genvar k = 1; k <= N; k++) begin : g_cordic
            always_comb
            begin
                if (!c_r_reg[k-1][31]) begin
                    c_u_next[k] = c_u_reg[k-1] - (c_v_reg[k-1] >>> (k - 1));
                    c_v_next[k] = c_v_reg[k-1] + (c_u_reg[k-1] >>> (k - 1));
                end else begin
                    c_u_next[k] = c_u_reg[k-1] + (c_v_reg[k-1] >>> (k - 1));
                    c_v_next[k] = c_v_reg[k-1] - (c_u_reg[k-1] >>> (k - 1));
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n) begin
                    c_vld_reg[k] <= 1'b0;
                end else if (c_en[k]) begin
                    c_vld_reg[k] <= c_vld_reg[k-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (c_en[k]) begin
                    c_u_reg[k]    <= c_u_next[k];
                    c_v_reg[k]    <= c_v_next[k];
                    c_side_reg[k] <= c_side_reg[k-1];
                end
            end

            // Residual is needed only by the iterations that follow
            if (k < N) begin : g_resid
                always_comb
                begin
                    if (!c_r_reg[k-1][31]) begin
                        c_r_next[k] = c_r_reg[k-1] - $signed(avr_pkg::atan_val(k - 1));
                    end else begin
                        c_r_next[k] = c_r_reg[k-1] + $signed(avr_pkg::atan_val(k - 1));
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (c_en[k]) begin
                        c_r_reg[k] <= c_r_next[k];
                    end
                end
            end
        end
    endgenerate

    // Place the rotated pair back on its axes; pass the rest through
    logic signed [31:0] fin_u;
    logic signed [31:0] fin_v;

    always_comb
    begin
        fin_u      = finish(c_u_reg[N]);
        fin_v      = finish(c_v_reg[N]);
        rot_x_next = c_side_reg[N].x;
        rot_y_next = c_side_reg[N].y;
        rot_z_next = c_side_reg[N].z;
        case (c_side_reg[N].mode)
            avr_pkg::MODE_HEADING:
            begin
                rot_x_next = fin_u;
                rot_y_next = fin_v;
            end
            avr_pkg::MODE_PITCH:
            begin
                rot_y_next = fin_u;
                rot_z_next = fin_v;
            end
            avr_pkg::MODE_BANK:
            begin
                rot_x_next = fin_u;
                rot_z_next = fin_v;
            end
            default:
            begin
                rot_x_next = c_side_reg[N].x;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else if (out_adv) begin
            out_vld_reg <= c_vld_reg[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv) begin
            rot_x_reg <= rot_x_next;
            rot_y_reg <= rot_y_next;
            rot_z_reg <= rot_z_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign rot_x     = rot_x_reg;
    assign rot_y     = rot_y_reg;
    assign rot_z     = rot_z_reg;

endmodule

FILE: src/avr_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module avr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] rot_x,
    input logic signed [31:0] rot_y,
    input logic signed [31:0] rot_z
);

    // Hold a stalled result item
    `AVR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `AVR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(rot_x) && $stable(rot_y) && $stable(rot_z))

    // Drop ready only when the output side is blocked
    `AVR_ASSERT_NOW(a_ready_blocked, !in_ready, out_valid && !out_ready)

    // Keep a stalled full pipeline full: ready then follows the output side
    `AVR_ASSERT_NEXT(a_full_stays, !in_ready && !out_ready, in_ready == out_ready)

endmodule

bind axis_vector_rotation avr_checker u_avr_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int LATENCY       = CORDIC_STAGES + 3;
    localparam int N_RANDOM      = 1250;
    localparam int CYCLE_LIMIT   = 400000;

    // Selector value with no axis behind it
    localparam logic [1:0] MODE_NONE = 2'd3;

    // Datapath constants: gain reciprocal in Q2.30, guard bits below the point
    localparam longint      GAIN_Q30   = 652032874;
    localparam int          EXTRA_BITS = 24;
    localparam logic [31:0] ANGLE_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);

    localparam logic signed [31:0] MAX_C = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_C = 32'sh8000_0000;
    localparam logic signed [31:0] UNIT  = 32'sh0001_0000;

    // atan(2^-i) in units of 2^-32 turn, entry 29 first
    localparam logic [29:0][31:0] ATAN_TURN = {
        32'h00000001, 32'h00000002, 32'h00000005, 32'h0000000A, 32'h00000014,
        32'h00000028, 32'h00000051, 32'h000000A2, 32'h00000145, 32'h0000028B,
        32'h00000517, 32'h00000A2F, 32'h0000145F, 32'h000028BE, 32'h0000517C,
        32'h0000A2F9, 32'h000145F3, 32'h00028BE6, 32'h000517CC, 32'h000A2F98,
        32'h00145F2E, 32'h0028BE53, 32'h00517C55, 32'h00A2F61E, 32'h0145D7E1,
        32'h028B0D43, 32'h051111D4, 32'h09FB385B, 32'h12E4051D, 32'h20000000
    };

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [15:0]        angle;
    } vec_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } rot_t;

    typedef struct packed {
        vec_item_t item;
        logic      known;
        rot_t      want;
    } stim_row_t;

    typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         mode;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [15:0]        angle;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;

    rot_t     rot_pending[$];
    rot_t     mon_want;
    int       errors     = 0;
    int       burst_left = 0;
    int       rx_tick    = 0;
    rx_mode_t rx_phase   = RX_OPEN;
    int       cycle_cnt;

    axis_vector_rotation #(
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .angle     (angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z)
    );

    // Round off the guard bits to nearest, clamp to 32 bits
    function automatic logic signed [31:0] round_sat(input longint acc);
        longint s;
        s = (acc + (longint'(1) << (EXTRA_BITS - 1))) >>> EXTRA_BITS;
        if (s > 64'sd2147483647)
            return MAX_C;
        if (s < -64'sd2147483648)
            return MIN_C;
        return 32'(s);
    endfunction

    // Rotate (a,b) counterclockwise by phi, a fraction of a turn
    function automatic void rotate_pair(
        input  logic signed [31:0] a,
        input  logic signed [31:0] b,
        input  logic [31:0]        phi,
        output logic signed [31:0] ra,
        output logic signed [31:0] rb
    );
        logic [31:0] p32;
        logic [31:0] qsum;
        logic [31:0] resid;
        logic [1:0]  quad;
        longint      u;
        longint      v;
        longint      t;
        longint      du;
        longint      dv;
        longint      r;
        p32   = phi << (32 - ANGLE_BITS);
        qsum  = p32 + 32'h2000_0000;
        quad  = qsum[31:30];
        resid = p32 - {quad, 30'd0};
        r     = longint'($signed(resid));
        u     = (longint'(a) * GAIN_Q30) >>> (30 - EXTRA_BITS);
        v     = (longint'(b) * GAIN_Q30) >>> (30 - EXTRA_BITS);

        // Exact quarter-turn pre-rotation
        case (quad)
            avr_pkg::QUAD_1:
            begin
                t = u;
                u = -v;
                v = t;
            end
            avr_pkg::QUAD_2:
            begin
                u = -u;
                v = -v;
            end
            avr_pkg::QUAD_3:
            begin
                t = u;
                u = v;
                v = -t;
            end
            default: ;
        endcase

        // Micro-rotations, each driving the residual angle toward zero
        for (int i = 0; i < CORDIC_STAGES && i < 30; i++)
        begin
            du = v >>> i;
            dv = u >>> i;
            if (r >= 0)
            begin
                u = u - du;
                v = v + dv;
                r = r - longint'(ATAN_TURN[i]);
            end
            else
            begin
                u = u + du;
                v = v - dv;
                r = r + longint'(ATAN_TURN[i]);
            end
        end
        ra = round_sat(u);
        rb = round_sat(v);
    endfunction

    function automatic rot_t predict_rotation(input vec_item_t it);
        rot_t        res;
        logic [31:0] th;
        logic [31:0] neg;
        th    = 32'(it.angle) & ANGLE_MASK;
        neg   = (32'd0 - th) & ANGLE_MASK;
        res.x = it.x;
        res.y = it.y;
        res.z = it.z;
        case (it.mode)
            avr_pkg::MODE_HEADING: rotate_pair(it.x, it.y, neg, res.x, res.y);
            avr_pkg::MODE_PITCH:   rotate_pair(it.y, it.z, neg, res.y, res.z);
            avr_pkg::MODE_BANK:    rotate_pair(it.x, it.z, th, res.x, res.z);
            default: ;
        endcase
        return res;
    endfunction

    function automatic stim_row_t row_of(
        input logic [1:0]         m,
        input logic signed [31:0] x,
        input logic signed [31:0] y,
        input logic signed [31:0] z,
        input logic [15:0]        ang,
        input logic               known,
        input logic signed [31:0] wx,
        input logic signed [31:0] wy,
        input logic signed [31:0] wz
    );
        stim_row_t row;
        row.item.mode  = m;
        row.item.x     = x;
        row.item.y     = y;
        row.item.z     = z;
        row.item.angle = ang;
        row.known      = known;
        row.want.x     = wx;
        row.want.y     = wy;
        row.want.z     = wz;
        return row;
    endfunction

    // Component mix: full range, rails, and values near the origin
    function automatic logic signed [31:0] random_comp();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 7))
            0:       return MAX_C;
            1:       return MIN_C;
            2:       return {{12{w[19]}}, w[19:0]};
            3:       return {{4{w[27]}}, w[27:0]};
            default: return w;
        endcase
    endfunction

    function automatic vec_item_t random_item();
        vec_item_t it;
        int        sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            it.mode = MODE_NONE;
        else if (sel <= 5)
            it.mode = avr_pkg::MODE_HEADING;
        else if (sel <= 10)
            it.mode = avr_pkg::MODE_PITCH;
        else
            it.mode = avr_pkg::MODE_BANK;
        it.x = random_comp();
        it.y = random_comp();
        it.z = random_comp();
        // Hit octant boundaries now and then, one step either side
        if ($urandom_range(0, 5) == 0)
            it.angle = 16'($urandom_range(0, 7) << 13) + 16'($urandom_range(0, 2)) - 16'd1;
        else
            it.angle = 16'($urandom);
        return it;
    endfunction

    // Open a gap between bursts; long bursts give stretches with no idling
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                gap        = 0;
                burst_left = $urandom_range(100, 250);
            end
            else
            begin
                gap        = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 24);
            end
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // Present one item, hold it until accepted, then queue its result
    task automatic drive_item(input vec_item_t it, input logic known, input rot_t want);
        mode     <= it.mode;
        vec_x    <= it.x;
        vec_y    <= it.y;
        vec_z    <= it.z;
        angle    <= it.angle;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (known)
            rot_pending.push_back(want);
        else
            rot_pending.push_back(predict_rotation(it));
    endtask

    task automatic check_field(
        input string              name,
        input logic signed [31:0] want,
        input logic signed [31:0] got
    );
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stall pattern, switching among open, light, heavy and periodic styles
    always @(posedge clk)
    begin
        rx_tick++;
        if (rx_tick % 256 == 0)
            rx_phase = rx_mode_t'($urandom_range(0, 3));
        case (rx_phase)
            RX_OPEN:  out_ready <= 1'b1;
            RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY: out_ready <= ($urandom_range(0, 1) != 0);
            default:  out_ready <= (rx_tick[4:3] != 2'b00);
        endcase
    end

    // Compare each delivered item against the oldest pending rotation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (rot_pending.size() == 0)
            begin
                $display("%0t: unexpected item, expected none actual %0d %0d %0d",
                         $time, rot_x, rot_y, rot_z);
                errors++;
            end
            else
            begin
                mon_want = rot_pending.pop_front();
                check_field("rot_x", mon_want.x, rot_x);
                check_field("rot_y", mon_want.y, rot_y);
                check_field("rot_z", mon_want.z, rot_z);
            end
        end
    end

    // Hard stop on a hang
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        mode      <= avr_pkg::MODE_HEADING;
        vec_x     <= '0;
        vec_y     <= '0;
        vec_z     <= '0;
        angle     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero pair rotates to zero; the free axis and the no-axis selector pass through
        rows.push_back(row_of(avr_pkg::MODE_HEADING, 0, 0, MAX_C, 16'h1234, 1'b1,
                              0, 0, MAX_C));
        rows.push_back(row_of(avr_pkg::MODE_PITCH, MIN_C, 0, 0, 16'hFFFF, 1'b1,
                              MIN_C, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_BANK, 0, 32'sh1234_5678, 0, 16'h8000, 1'b1,
                              0, 32'sh1234_5678, 0));
        rows.push_back(row_of(MODE_NONE, MAX_C, MIN_C, 32'sh1234_5678, 16'hFFFF, 1'b1,
                              MAX_C, MIN_C, 32'sh1234_5678));
        rows.push_back(row_of(MODE_NONE, MIN_C, MAX_C, -1, 16'h0000, 1'b1,
                              MIN_C, MAX_C, -1));
        // Quadrant and octant boundaries on unit vectors
        rows.push_back(row_of(avr_pkg::MODE_HEADING, UNIT, 0, 0, 16'h0000, 1'b0, 0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_HEADING, UNIT, 0, 0, 16'h4000, 1'b0, 0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_HEADING, UNIT, 0, 0, 16'h8000, 1'b0, 0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_HEADING, UNIT, 0, 0, 16'hC000, 1'b0, 0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_PITCH, 0, UNIT, UNIT, 16'h2000, 1'b0, 0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_PITCH, 0, UNIT, -UNIT, 16'h1FFF, 1'b0, 0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_BANK, UNIT, 0, -UNIT, 16'hE000, 1'b0, 0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_BANK, -UNIT, 5, UNIT, 16'h6000, 1'b0, 0, 0, 0));
        // Rails, where the diagonal saturates
        rows.push_back(row_of(avr_pkg::MODE_HEADING, MAX_C, MAX_C, 0, 16'h2000, 1'b0,
                              0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_HEADING, MIN_C, MIN_C, 0, 16'h2000, 1'b0,
                              0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_PITCH, MAX_C, MAX_C, MIN_C, 16'hE000, 1'b0,
                              0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_BANK, MIN_C, MAX_C, MIN_C, 16'hA000, 1'b0,
                              0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_BANK, MAX_C, MIN_C, MAX_C, 16'hFFFF, 1'b0,
                              0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_HEADING, MAX_C, MIN_C, MAX_C, 16'h0000, 1'b0,
                              0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_BANK, 0, 0, MAX_C, 16'h4000, 1'b0, 0, 0, 0));
        // Rounding right at the origin
        rows.push_back(row_of(avr_pkg::MODE_HEADING, -1, -1, -1, 16'h0001, 1'b0, 0, 0, 0));
        rows.push_back(row_of(avr_pkg::MODE_PITCH, 1, 1, 1, 16'h0001, 1'b0, 0, 0, 0));

        foreach (rows[k])
        begin
            pace_sender();
            drive_item(rows[k].item, rows[k].known, rows[k].want);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            pace_sender();
            drive_item(random_item(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        // Drain, then give stray items time to show up
        while (rot_pending.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);

        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/avr_pkg.sv
src/axis_vector_rotation.sv
src/avr_checker.sv
tb/sv/tb.sv
